// ===== rtl/jsu_pkg.sv =====
// Shared types, constants and decode functions for the JSON string unescaper.
package jsu_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last_of_run;
   } rsp_type;

   // Everything one request produces: up to four bytes, then an optional end or error.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      byte_count;
      logic            has_term;
      logic [1:0]      term_kind;
   } run_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } utf8_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       valid;
      logic       is_u;
      logic [7:0] value;
   } esc_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.valid = 1'b1;
         r.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.valid = 1'b1;
         r.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.valid = 1'b1;
         r.value = 4'(b - 8'h37);
      end
      return r;
   endfunction

   function automatic esc_type escape_decode(input logic [7:0] b);
      esc_type r;
      r = '0;
      unique case (b)
         CHAR_QUOTE:     begin r.valid = 1'b1; r.value = CHAR_QUOTE;     end
         CHAR_BACKSLASH: begin r.valid = 1'b1; r.value = CHAR_BACKSLASH; end
         CHAR_SLASH:     begin r.valid = 1'b1; r.value = CHAR_SLASH;     end
         8'h62:          begin r.valid = 1'b1; r.value = 8'h08;          end
         8'h66:          begin r.valid = 1'b1; r.value = 8'h0C;          end
         8'h6E:          begin r.valid = 1'b1; r.value = 8'h0A;          end
         8'h72:          begin r.valid = 1'b1; r.value = 8'h0D;          end
         8'h74:          begin r.valid = 1'b1; r.value = 8'h09;          end
         CHAR_LOWER_U:   begin r.is_u = 1'b1;                            end
         default:        begin r = '0;                                   end
      endcase
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] code);
      utf8_type r;
      r = '0;
      if (code < 21'h80) begin
         r.bytes[0] = code[7:0];
         r.count    = 3'd1;
      end else if (code < 21'h800) begin
         r.bytes[0] = {3'b110, code[10:6]};
         r.bytes[1] = {2'b10, code[5:0]};
         r.count    = 3'd2;
      end else if (code < 21'h10000) begin
         r.bytes[0] = {4'b1110, code[15:12]};
         r.bytes[1] = {2'b10, code[11:6]};
         r.bytes[2] = {2'b10, code[5:0]};
         r.count    = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, code[20:18]};
         r.bytes[1] = {2'b10, code[17:12]};
         r.bytes[2] = {2'b10, code[11:6]};
         r.bytes[3] = {2'b10, code[5:0]};
         r.count    = 3'd4;
      end
      return r;
   endfunction

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: decodes each request byte into a run of output bytes and a terminator.
module jsu_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  jsu_pkg::req_type req_data,
   input  logic            queue_full,
   output logic            push,
   output jsu_pkg::run_type push_run
);
   import jsu_pkg::*;

   localparam logic [2:0] MODE_NORMAL  = 3'd0;
   localparam logic [2:0] MODE_ESC     = 3'd1;
   localparam logic [2:0] MODE_HEX1    = 3'd2;
   localparam logic [2:0] MODE_HELD    = 3'd3;
   localparam logic [2:0] MODE_HELD_BS = 3'd4;
   localparam logic [2:0] MODE_HEX2    = 3'd5;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] held_ff, held_in;

   logic        accept;
   logic [7:0]  b;
   hex_type     hex;
   esc_type     esc;
   logic [15:0] acc_next;
   logic        do_norm, do_esc, flush, extra_vld, code_vld, term_end, term_err;
   logic [7:0]  extra;
   logic [20:0] code;
   utf8_type    enc;
   run_type     run;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.source_byte;
   assign hex       = hex_decode(b);
   assign esc       = escape_decode(b);
   assign acc_next  = {acc_ff[11:0], hex.value};

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      held_in   = held_ff;
      do_norm   = 1'b0;
      do_esc    = 1'b0;
      flush     = 1'b0;
      extra_vld = 1'b0;
      extra     = 8'h00;
      code_vld  = 1'b0;
      code      = '0;
      term_end  = 1'b0;
      term_err  = 1'b0;

      unique case (mode_ff)
         MODE_ESC: begin
            do_esc = 1'b1;
         end
         MODE_HEX1, MODE_HEX2: begin
            if (!hex.valid) begin
               term_err = 1'b1;
            end else if (cnt_ff != 2'd3) begin
               acc_in = acc_next;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               acc_in  = '0;
               cnt_in  = '0;
               mode_in = MODE_NORMAL;
               if (mode_ff == MODE_HEX1) begin
                  if (acc_next >= 16'hD800 && acc_next <= 16'hDBFF) begin
                     held_in = acc_next;
                     mode_in = MODE_HELD;
                  end else begin
                     code_vld = 1'b1;
                     code     = {5'b0, acc_next};
                  end
               end else begin
                  code_vld = 1'b1;
                  if (acc_next >= 16'hDC00 && acc_next <= 16'hDFFF) begin
                     code = 21'h10000 + {1'b0, held_ff[9:0], acc_next[9:0]};
                  end else begin
                     code = {5'b0, held_ff};
                  end
                  held_in = '0;
               end
            end
         end
         MODE_HELD: begin
            if (b == CHAR_BACKSLASH) begin
               mode_in = MODE_HELD_BS;
            end else begin
               flush   = 1'b1;
               held_in = '0;
               do_norm = 1'b1;
            end
         end
         MODE_HELD_BS: begin
            if (b == CHAR_LOWER_U) begin
               mode_in = MODE_HEX2;
               acc_in  = '0;
               cnt_in  = '0;
            end else begin
               flush   = 1'b1;
               held_in = '0;
               do_esc  = 1'b1;
            end
         end
         default: begin
            do_norm = 1'b1;
         end
      endcase

      if (do_norm) begin
         mode_in = MODE_NORMAL;
         if (b == CHAR_QUOTE) begin
            term_end = 1'b1;
         end else if (b == CHAR_BACKSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            extra_vld = 1'b1;
            extra     = b;
         end
      end

      if (do_esc) begin
         mode_in = MODE_NORMAL;
         if (esc.valid) begin
            extra_vld = 1'b1;
            extra     = esc.value;
         end else if (esc.is_u) begin
            mode_in = MODE_HEX1;
            acc_in  = '0;
            cnt_in  = '0;
         end else begin
            term_err = 1'b1;
         end
      end

      if (req_data.is_final && !term_end) begin
         term_err = 1'b1;
      end

      if (term_err || term_end) begin
         mode_in = MODE_NORMAL;
         acc_in  = '0;
         cnt_in  = '0;
         held_in = '0;
      end
   end

   assign enc = utf8_encode(code_vld ? code : {5'b0, held_ff});

   always_comb begin
      run = '0;
      if (code_vld) begin
         run.bytes      = enc.bytes;
         run.byte_count = enc.count;
      end else if (flush) begin
         run.bytes      = enc.bytes;
         run.byte_count = enc.count;
         if (extra_vld) begin
            run.bytes[3]   = extra;
            run.byte_count = 3'd4;
         end
      end else if (extra_vld) begin
         run.bytes[0]   = extra;
         run.byte_count = 3'd1;
      end
      if (term_err) begin
         run.bytes      = '0;
         run.byte_count = '0;
         run.has_term   = 1'b1;
         run.term_kind  = KIND_ERROR;
      end else if (term_end) begin
         run.has_term   = 1'b1;
         run.term_kind  = KIND_END;
      end
   end

   assign push     = accept && (run.byte_count != 3'd0 || run.has_term);
   assign push_run = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         held_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== rtl/jsu_queue.sv =====
// Small queue of decoded runs between the front end and the serializer.
module jsu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::run_type push_run,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output jsu_pkg::run_type head_run
);
   import jsu_pkg::*;

   run_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head_run = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: walks the head run into the output register, one result per cycle unless stalled.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             nonempty,
   input  jsu_pkg::run_type head_run,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [2:0] total;
   logic       is_byte, is_last, load;

   assign total   = head_run.byte_count + 3'(head_run.has_term);
   assign is_byte = ({1'b0, idx_ff} < head_run.byte_count);
   assign is_last = ({1'b0, idx_ff} + 3'd1 == total);
   assign load    = nonempty && (!rsp_valid_ff || rsp_ready);
   assign pop     = load && is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         idx_in                  = is_last ? 2'd0 : idx_ff + 2'd1;
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = is_byte ? head_run.bytes[idx_ff] : 8'h00;
         rsp_data_in.kind        = is_byte ? KIND_DATA : head_run.term_kind;
         rsp_data_in.last_of_run = is_last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// One request byte is accepted per cycle whenever the four-entry run queue has room; the
// decoder turns it into a run of zero to four results in the same cycle. The serializer
// sends one result per cycle from a registered output while rsp_ready is high, so a \u escape
// that expands to three or four bytes occupies the output for each of its bytes, and a sustained
// input rate of one byte per cycle holds while the average run length stays at one or below.
// A request that yields no result (a backslash, a hex digit in progress) pushes nothing.
module json_string_unescape_utf8 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);
   import jsu_pkg::*;

   logic    push, pop, full, nonempty;
   run_type push_run, head_run;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_run   (push_run)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .full     (full),
      .pop      (pop),
      .nonempty (nonempty),
      .head_run (head_run)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .nonempty  (nonempty),
      .head_run  (head_run),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
